### design/hbbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbbc_pkg
// Types and constants for the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

    localparam int DEF_BUFFER_COUNT = 32;
    localparam int DEF_BUCKET_COUNT = 13;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PIN     = 2'd2,
        ACT_UNPIN   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  buffer_index;
    } req_t;

    typedef struct packed {
        logic [4:0] slot;
        logic       hit;
        logic       needs_disk_read;
        logic [1:0] status;
    } rsp_t;

    // per-slot metadata held in one memory word
    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block;
        logic [7:0]  count;
        logic        contents_valid;
    } meta_t;

endpackage
`default_nettype wire

### design/hashed_block_buffer_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Buffer-cache metadata engine: hashed bucket lists with reference counts.
// ----------------------------------------------------------------------------
// One request is handled at a time. Release, pin and unpin read the slot's
// metadata, then compare and update its count, and respond from S_DONE. A read
// first reduces the block number modulo the bucket count, one byte per cycle,
// then walks the target bucket, one memory read and one compare per entry,
// until a match or the end of the list. A miss scans the buckets from the
// hash onward, reading each head and then its entries, and unlinks and
// relinks the victim. The list walks through the synchronous metadata and
// link memories set the latency. The memories need no clearing pass after
// reset: per-entry valid bits supply the reset contents.
module hashed_block_buffer_cache
    import hbbc_pkg::*;
#(
    parameter int BUFFER_COUNT = DEF_BUFFER_COUNT,
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  wire  rsp_stall,
    output rsp_t rsp
);

    localparam int SW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
    localparam int LW = $clog2(BUFFER_COUNT + 1);
    localparam int KW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int BW = $clog2(BUCKET_COUNT + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(BUFFER_COUNT);

    // byte-wise remainder tables: entry i holds (i * scale) mod bucket count
    typedef logic [255:0][KW-1:0] mod_tab_t;

    function automatic mod_tab_t build_mod_tab(int scale);
        mod_tab_t t;
        for (int i = 0; i < 256; i++)
            t[i] = KW'((i * scale) % BUCKET_COUNT);
        return t;
    endfunction

    localparam mod_tab_t LO_TAB = build_mod_tab(1);
    localparam mod_tab_t HI_TAB = build_mod_tab(256);

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_LOOK_RD, S_LOOK_CMP, S_SCAN_HEAD, S_SCAN_RD,
        S_SCAN_CMP, S_UNLINK, S_RELINK, S_ACT_RD, S_ACT_CMP, S_DONE
    } state_t;

    state_t          state_reg;
    req_t            req_reg;
    logic [1:0]      byte_cnt_reg;
    logic [KW-1:0]   hash_reg;
    logic [LW-1:0]   cur_reg;
    logic [LW-1:0]   prev_reg;
    logic [LW-1:0]   steps_reg;
    logic [LW-1:0]   vnext_reg;
    logic [KW-1:0]   bkt_reg;
    logic [BW-1:0]   bcnt_reg;
    rsp_t            pend_reg;
    rsp_t            rsp_reg;
    logic            rsp_valid_reg;
    logic [LW-1:0]   head_reg [BUCKET_COUNT];

    // memories and their valid bits
    meta_t           meta_mem [BUFFER_COUNT];
    logic [LW-1:0]   next_mem [BUFFER_COUNT];
    logic [BUFFER_COUNT-1:0] meta_set_reg;
    logic [BUFFER_COUNT-1:0] next_set_reg;
    meta_t           meta_q;
    logic [LW-1:0]   next_q;
    logic            meta_vld_q;
    logic            next_vld_q;
    logic [SW-1:0]   rd_slot_q;

    logic [SW-1:0]   rd_slot;
    logic            meta_we;
    logic [SW-1:0]   meta_wa;
    meta_t           meta_wd;
    logic            next_we;
    logic [SW-1:0]   next_wa;
    logic [LW-1:0]   next_wd;

    meta_t           meta_rd;
    logic [LW-1:0]   next_rd;
    logic [7:0]      hash_byte;
    logic [KW:0]     mod_sum;
    logic [KW-1:0]   mod_next;
    logic [KW-1:0]   head_ra;
    logic [LW-1:0]   head_rd;
    logic            match;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        meta_rd = meta_vld_q ? meta_q : '0;
        if (next_vld_q)
            next_rd = next_q;
        else if (32'(rd_slot_q) >= BUCKET_COUNT)
            next_rd = LW'(32'(rd_slot_q) - BUCKET_COUNT);
        else
            next_rd = NULL_LINK;
        match = (meta_rd.device == req_reg.device) &&
                (meta_rd.block == req_reg.block_number);
    end

    // one byte of the remainder by the bucket count per cycle, MSB first
    always_comb
    begin
        hash_byte = req_reg.block_number[{~byte_cnt_reg, 3'b000} +: 8];
        mod_sum   = (KW+1)'(HI_TAB[8'(hash_reg)]) + (KW+1)'(LO_TAB[hash_byte]);
        if (mod_sum >= (KW+1)'(BUCKET_COUNT))
            mod_next = KW'(mod_sum - (KW+1)'(BUCKET_COUNT));
        else
            mod_next = mod_sum[KW-1:0];
    end

    always_comb
    begin
        case (state_reg)
            S_HASH:      head_ra = mod_next;
            S_SCAN_HEAD: head_ra = bkt_reg;
            default:     head_ra = hash_reg;
        endcase
        head_rd = head_reg[head_ra];
    end

    always_comb
    begin
        rd_slot = cur_reg[SW-1:0];
        meta_we = 1'b0;
        meta_wa = cur_reg[SW-1:0];
        meta_wd = meta_rd;
        next_we = 1'b0;
        next_wa = cur_reg[SW-1:0];
        next_wd = head_rd;
        unique case (state_reg)
            S_LOOK_CMP:
            begin
                if (match && meta_rd.count != COUNT_MAX)
                begin
                    meta_we = 1'b1;
                    meta_wd.count = meta_rd.count + 8'd1;
                    meta_wd.contents_valid = 1'b1;
                end
            end
            S_UNLINK:
            begin
                meta_we = 1'b1;
                meta_wd.device = req_reg.device;
                meta_wd.block = req_reg.block_number;
                meta_wd.count = 8'd1;
                meta_wd.contents_valid = 1'b1;
                if (prev_reg != NULL_LINK)
                begin
                    next_we = 1'b1;
                    next_wa = prev_reg[SW-1:0];
                    next_wd = vnext_reg;
                end
            end
            S_RELINK:
            begin
                next_we = 1'b1;
            end
            S_ACT_CMP:
            begin
                if (req_reg.action == ACT_PIN)
                begin
                    if (meta_rd.count != COUNT_MAX)
                    begin
                        meta_we = 1'b1;
                        meta_wd.count = meta_rd.count + 8'd1;
                    end
                end
                else if (meta_rd.count != 8'd0)
                begin
                    meta_we = 1'b1;
                    meta_wd.count = meta_rd.count - 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_wa] <= meta_wd;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        meta_q    <= meta_mem[rd_slot];
        next_q    <= next_mem[rd_slot];
        rd_slot_q <= rd_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_set_reg <= '0;
            next_set_reg <= '0;
            meta_vld_q   <= 1'b0;
            next_vld_q   <= 1'b0;
        end
        else
        begin
            if (meta_we)
                meta_set_reg[meta_wa] <= 1'b1;
            if (next_we)
                next_set_reg[next_wa] <= 1'b1;
            meta_vld_q <= meta_set_reg[rd_slot];
            next_vld_q <= next_set_reg[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            pend_reg      <= '0;
            req_reg       <= '0;
            byte_cnt_reg  <= '0;
            hash_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            steps_reg     <= '0;
            vnext_reg     <= '0;
            bkt_reg       <= '0;
            bcnt_reg      <= '0;
            for (int k = 0; k < BUCKET_COUNT; k++)
            begin
                if (k < BUFFER_COUNT)
                    head_reg[k] <= LW'(k + BUCKET_COUNT * ((BUFFER_COUNT - 1 - k) / BUCKET_COUNT));
                else
                    head_reg[k] <= NULL_LINK;
            end
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg      <= req;
                        hash_reg     <= '0;
                        byte_cnt_reg <= '0;
                        cur_reg      <= LW'(req.buffer_index);
                        pend_reg     <= '{slot: req.buffer_index, hit: 1'b0,
                                          needs_disk_read: 1'b0, status: ST_OK};
                        if (req.action == ACT_READ)
                            state_reg <= S_HASH;
                        else if (32'(req.buffer_index) < BUFFER_COUNT)
                            state_reg <= S_ACT_RD;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_HASH:
                begin
                    hash_reg     <= mod_next;
                    byte_cnt_reg <= byte_cnt_reg + 2'd1;
                    if (byte_cnt_reg == 2'd3)
                    begin
                        cur_reg   <= head_rd;
                        steps_reg <= '0;
                        state_reg <= S_LOOK_RD;
                    end
                end
                S_LOOK_RD:
                begin
                    if (cur_reg == NULL_LINK || steps_reg == NULL_LINK)
                    begin
                        bkt_reg   <= hash_reg;
                        bcnt_reg  <= '0;
                        state_reg <= S_SCAN_HEAD;
                    end
                    else
                        state_reg <= S_LOOK_CMP;
                end
                S_LOOK_CMP:
                begin
                    if (match)
                    begin
                        pend_reg.slot <= 5'(cur_reg);
                        pend_reg.hit  <= 1'b1;
                        if (meta_rd.count == COUNT_MAX)
                            pend_reg.status <= ST_SATURATED;
                        else
                            pend_reg.needs_disk_read <= ~meta_rd.contents_valid;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= next_rd;
                        steps_reg <= steps_reg + LW'(1);
                        state_reg <= S_LOOK_RD;
                    end
                end
                S_SCAN_HEAD:
                begin
                    if (bcnt_reg == BW'(BUCKET_COUNT))
                    begin
                        pend_reg.slot   <= '0;
                        pend_reg.status <= ST_NO_FREE;
                        state_reg       <= S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= head_rd;
                        prev_reg  <= NULL_LINK;
                        steps_reg <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if (cur_reg == NULL_LINK || steps_reg == NULL_LINK)
                    begin
                        if (32'(bkt_reg) == BUCKET_COUNT - 1)
                            bkt_reg <= '0;
                        else
                            bkt_reg <= bkt_reg + KW'(1);
                        bcnt_reg  <= bcnt_reg + BW'(1);
                        state_reg <= S_SCAN_HEAD;
                    end
                    else
                        state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (meta_rd.count == 8'd0)
                    begin
                        vnext_reg <= next_rd;
                        state_reg <= S_UNLINK;
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= next_rd;
                        steps_reg <= steps_reg + LW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UNLINK:
                begin
                    if (prev_reg == NULL_LINK)
                        head_reg[bkt_reg] <= vnext_reg;
                    state_reg <= S_RELINK;
                end
                S_RELINK:
                begin
                    head_reg[hash_reg]       <= cur_reg;
                    pend_reg.slot            <= 5'(cur_reg);
                    pend_reg.needs_disk_read <= 1'b1;
                    state_reg                <= S_DONE;
                end
                S_ACT_RD:
                begin
                    state_reg <= S_ACT_CMP;
                end
                S_ACT_CMP:
                begin
                    if (req_reg.action == ACT_PIN)
                    begin
                        if (meta_rd.count == COUNT_MAX)
                            pend_reg.status <= ST_SATURATED;
                    end
                    else if (meta_rd.count == 8'd0)
                        pend_reg.status <= ST_UNDERFLOW;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= pend_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
